// ----- sv/dda_pkg.sv -----
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants for the line rasterizer with color interpolation.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int COLOR_BITS = 24;
    localparam int POS_BITS   = COORD_BITS + FRAC_BITS;
    localparam int INC_BITS   = FRAC_BITS + 2;
    localparam int CACC_BITS  = COLOR_BITS + 1 + FRAC_BITS;
    localparam int CNT_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * COORD_BITS + 2;
    localparam int DVD_BITS   = COLOR_BITS + FRAC_BITS;
    localparam int ADDR_BITS  = 32;
    localparam int BPP_BITS   = 4;
    localparam int PITCH_BITS = 16;

    localparam logic       MODE_LOAD = 1'b0;
    localparam logic       MODE_STEP = 1'b1;
    localparam logic [1:0] REG_BPP   = 2'd0;
    localparam logic [1:0] REG_PITCH = 2'd1;
    localparam logic [1:0] REG_BASE  = 2'd2;

    typedef struct packed {
        logic                         mode;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic        [COLOR_BITS-1:0] start_color;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic        [COLOR_BITS-1:0] end_color;
    } request_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  pixel_address;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SQRT = 5'b00010,
        ST_DIVX = 5'b00100,
        ST_DIVY = 5'b01000,
        ST_DIVC = 5'b10000
    } seq_state_t;

endpackage

// ----- sv/dda_isqrt.sv -----
// ----------------------------------------------------------------------------
// dda_isqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dda_isqrt
    import dda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQ_BITS-1:0]  radicand,
    output logic                done,
    output logic [CNT_BITS-1:0] root
);

    logic [SQ_BITS-1:0] n_reg,   n_next;
    logic [SQ_BITS-1:0] res_reg, res_next;
    logic [SQ_BITS-1:0] bit_reg, bit_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [SQ_BITS:0]   trial;

    always_comb
    begin
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start)
        begin
            n_next    = radicand;
            res_next  = '0;
            bit_next  = {2'b01, {(SQ_BITS-2){1'b0}}};
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, n_reg} >= trial)
            begin
                n_next   = n_reg - trial[SQ_BITS-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[CNT_BITS-1:0];

endmodule

// ----- sv/dda_div.sv -----
// ----------------------------------------------------------------------------
// dda_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dda_div
    import dda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_BITS-1:0] dividend,
    input  logic [CNT_BITS-1:0] divisor,
    output logic                done,
    output logic [DVD_BITS-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_BITS);

    logic [DVD_BITS-1:0] q_reg,   q_next;
    logic [CNT_BITS-1:0] rem_reg, rem_next;
    logic [CNT_BITS-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS:0]   shifted;
    logic [CNT_BITS:0]   diff;

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, q_reg[DVD_BITS-1]};
        diff      = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DVD_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The dividend shifts out at the top while quotient bits enter below.
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = diff[CNT_BITS-1:0];
                q_next   = {q_reg[DVD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[CNT_BITS-1:0];
                q_next   = {q_reg[DVD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- sv/dda_line_color_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// dda_line_color_interpolator_top
// Line rasterizer: sets up a line, then emits one pixel address and color per
// step request.
// ----------------------------------------------------------------------------
// A step request yields one pixel while pixels remain; a load request holds
// off the next request while the bit-serial square root forms the step count
// and then while the shared bit-serial divider makes three passes for the x, y
// and color increments. A zero-length line skips the divider. No request is
// taken while a load is in progress or a pixel waits at the output under stall.
module dda_line_color_interpolator_top
    import dda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  request_valid,
    output logic                  request_stall,
    input  request_t              request,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  write_en,
    input  logic [1:0]            write_index,
    input  logic [ADDR_BITS-1:0]  write_data
);

    logic [BPP_BITS-1:0]   bpp_reg;
    logic [PITCH_BITS-1:0] pitch_reg;
    logic [ADDR_BITS-1:0]  base_reg;

    seq_state_t state_reg, state_next;

    logic signed [POS_BITS-1:0]  x_pos_reg, x_pos_next;
    logic signed [POS_BITS-1:0]  y_pos_reg, y_pos_next;
    logic signed [CACC_BITS-1:0] c_acc_reg, c_acc_next;
    logic signed [INC_BITS-1:0]  x_inc_reg, x_inc_next;
    logic signed [INC_BITS-1:0]  y_inc_reg, y_inc_next;
    logic signed [CACC_BITS-1:0] c_inc_reg, c_inc_next;
    logic [CNT_BITS-1:0]         left_reg, left_next;

    logic signed [COORD_BITS:0]   dx_reg, dx_next;
    logic signed [COORD_BITS:0]   dy_reg, dy_next;
    logic signed [COLOR_BITS:0]   dc_reg, dc_next;

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    logic                sqrt_start;
    logic                sqrt_done;
    logic [SQ_BITS-1:0]  sq;
    logic [CNT_BITS-1:0] root;
    logic                div_start_reg, div_start_next;
    logic                div_done;
    logic [DVD_BITS-1:0] dividend;
    logic [DVD_BITS-1:0] quotient;
    logic [COLOR_BITS-1:0] mag;
    logic                  div_neg;
    logic [CACC_BITS-1:0]  signed_q;

    logic accept;
    logic emit;

    logic signed [COORD_BITS-1:0] xi;
    logic signed [COORD_BITS-1:0] yi;
    logic signed [COLOR_BITS:0]   ci;
    logic [ADDR_BITS-1:0]         x_off;
    logic [ADDR_BITS-1:0]         y_off;

    logic signed [COORD_BITS:0]   ldx;
    logic signed [COORD_BITS:0]   ldy;
    logic [2*COORD_BITS+1:0]      dx2;
    logic [2*COORD_BITS+1:0]      dy2;

    assign request_stall = (state_reg != ST_IDLE) || (out_valid_reg && result_stall);
    assign accept        = request_valid && !request_stall;
    assign emit          = accept && (request.mode == MODE_STEP) && (left_reg != '0);
    assign sqrt_start    = accept && (request.mode == MODE_LOAD);

    assign ldx = (COORD_BITS+1)'(request.end_x) - (COORD_BITS+1)'(request.start_x);
    assign ldy = (COORD_BITS+1)'(request.end_y) - (COORD_BITS+1)'(request.start_y);

    // Squared length is formed at load from the request fields directly.
    always_comb
    begin
        dx2 = '0;
        dy2 = '0;
        sq  = '0;
        dx2 = $unsigned((2*COORD_BITS+2)'(dx_next) * (2*COORD_BITS+2)'(dx_next));
        dy2 = $unsigned((2*COORD_BITS+2)'(dy_next) * (2*COORD_BITS+2)'(dy_next));
        sq  = SQ_BITS'(dx2 + dy2);
    end

    dda_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sq),
        .done     (sqrt_done),
        .root     (root)
    );

    // Divider source follows the sequencer state.
    always_comb
    begin
        mag     = '0;
        div_neg = 1'b0;
        unique case (state_reg)
            ST_DIVY:
            begin
                mag     = COLOR_BITS'(dy_reg < 0 ? -dy_reg : dy_reg);
                div_neg = dy_reg < 0;
            end
            ST_DIVC:
            begin
                mag     = COLOR_BITS'(dc_reg < 0 ? -dc_reg : dc_reg);
                div_neg = dc_reg < 0;
            end
            default:
            begin
                mag     = COLOR_BITS'(dx_reg < 0 ? -dx_reg : dx_reg);
                div_neg = dx_reg < 0;
            end
        endcase
        dividend = {mag, {FRAC_BITS{1'b0}}};
        signed_q = div_neg ? -{1'b0, quotient} : {1'b0, quotient};
    end

    dda_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dividend),
        .divisor  (left_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Fixed-point values truncate toward zero: round up negatives with a fraction.
    always_comb
    begin
        xi = COORD_BITS'(x_pos_reg >>> FRAC_BITS)
           + COORD_BITS'(x_pos_reg[POS_BITS-1] && (x_pos_reg[FRAC_BITS-1:0] != '0));
        yi = COORD_BITS'(y_pos_reg >>> FRAC_BITS)
           + COORD_BITS'(y_pos_reg[POS_BITS-1] && (y_pos_reg[FRAC_BITS-1:0] != '0));
        ci = (COLOR_BITS+1)'(c_acc_reg >>> FRAC_BITS)
           + (COLOR_BITS+1)'(c_acc_reg[CACC_BITS-1] && (c_acc_reg[FRAC_BITS-1:0] != '0));
        x_off = ADDR_BITS'($unsigned(ADDR_BITS'(xi)) * {{(ADDR_BITS-BPP_BITS){1'b0}}, bpp_reg});
        y_off = ADDR_BITS'($unsigned(ADDR_BITS'(yi))
              * {{(ADDR_BITS-PITCH_BITS){1'b0}}, pitch_reg});
    end

    always_comb
    begin
        state_next     = state_reg;
        x_pos_next     = x_pos_reg;
        y_pos_next     = y_pos_reg;
        c_acc_next     = c_acc_reg;
        x_inc_next     = x_inc_reg;
        y_inc_next     = y_inc_reg;
        c_inc_next     = c_inc_reg;
        left_next      = left_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dc_next        = dc_reg;
        div_start_next = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (sqrt_start)
        begin
            dx_next = ldx;
            dy_next = ldy;
            dc_next = $signed({1'b0, request.end_color}) - $signed({1'b0, request.start_color});
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sqrt_start)
                begin
                    x_pos_next = {request.start_x, {FRAC_BITS{1'b0}}};
                    y_pos_next = {request.start_y, {FRAC_BITS{1'b0}}};
                    c_acc_next = {1'b0, request.start_color, {FRAC_BITS{1'b0}}};
                    state_next = ST_SQRT;
                end
                else if (emit)
                begin
                    out_next.pixel_address = base_reg + x_off + y_off;
                    out_next.pixel_color   = ci[COLOR_BITS-1:0];
                    out_next.last_pixel    = (left_reg == CNT_BITS'(1));
                    out_valid_next         = 1'b1;
                    x_pos_next = x_pos_reg + POS_BITS'(x_inc_reg);
                    y_pos_next = y_pos_reg + POS_BITS'(y_inc_reg);
                    c_acc_next = c_acc_reg + c_inc_reg;
                    left_next  = left_reg - 1'b1;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    left_next  = root;
                    x_inc_next = '0;
                    y_inc_next = '0;
                    c_inc_next = '0;
                    if (root == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        div_start_next = 1'b1;
                        state_next     = ST_DIVX;
                    end
                end
            end
            ST_DIVX:
            begin
                if (div_done)
                begin
                    x_inc_next     = signed_q[INC_BITS-1:0];
                    div_start_next = 1'b1;
                    state_next     = ST_DIVY;
                end
            end
            ST_DIVY:
            begin
                if (div_done)
                begin
                    y_inc_next     = signed_q[INC_BITS-1:0];
                    div_start_next = 1'b1;
                    state_next     = ST_DIVC;
                end
            end
            ST_DIVC:
            begin
                if (div_done)
                begin
                    c_inc_next = signed_q;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            x_pos_reg     <= '0;
            y_pos_reg     <= '0;
            c_acc_reg     <= '0;
            x_inc_reg     <= '0;
            y_inc_reg     <= '0;
            c_inc_reg     <= '0;
            left_reg      <= '0;
            bpp_reg       <= BPP_BITS'(4);
            pitch_reg     <= PITCH_BITS'(4096);
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_start_reg <= div_start_next;
            x_pos_reg     <= x_pos_next;
            y_pos_reg     <= y_pos_next;
            c_acc_reg     <= c_acc_next;
            x_inc_reg     <= x_inc_next;
            y_inc_reg     <= y_inc_next;
            c_inc_reg     <= c_inc_next;
            left_reg      <= left_next;
            if (write_en)
            begin
                unique case (write_index)
                    REG_BPP:   bpp_reg   <= write_data[BPP_BITS-1:0];
                    REG_PITCH: pitch_reg <= write_data[PITCH_BITS-1:0];
                    REG_BASE:  base_reg  <= write_data;
                    default:   base_reg  <= base_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        dc_reg  <= dc_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- verif/dda_line_color_interpolator_top_test.sv -----
// ----------------------------------------------------------------------------
// dda_line_color_interpolator_top_test
// Drives line loads and pixel steps with random idling and stalls, predicts
// every pixel's address, color and last flag, and checks the block's results
// against the predictions in order.
// ----------------------------------------------------------------------------
import dda_pkg::*;

class pixel_scoreboard;

    // Line setup and frame buffer settings, as the block holds them.
    logic [BPP_BITS-1:0]   bytes_per_pixel;
    logic [PITCH_BITS-1:0] row_pitch;
    logic [ADDR_BITS-1:0]  base_address;
    logic [POS_BITS-1:0]   x_pos;
    logic [POS_BITS-1:0]   y_pos;
    logic [CACC_BITS-1:0]  color_acc;
    logic [INC_BITS-1:0]   x_inc;
    logic [INC_BITS-1:0]   y_inc;
    logic [CACC_BITS-1:0]  color_inc;
    logic [CNT_BITS-1:0]   pixels_left;
    result_t               pending_pixels[$];
    int                    mismatches;
    int                    pixels_seen;

    function new();
        bytes_per_pixel = 4;
        row_pitch       = 4096;
        base_address    = 0;
        x_pos           = '0;
        y_pos           = '0;
        color_acc       = '0;
        x_inc           = '0;
        y_inc           = '0;
        color_inc       = '0;
        pixels_left     = '0;
        mismatches      = 0;
        pixels_seen     = 0;
    endfunction

    function void write_register(logic [1:0] index, logic [ADDR_BITS-1:0] value);
        case (index)
            REG_BPP:   bytes_per_pixel = value[BPP_BITS-1:0];
            REG_PITCH: row_pitch       = value[PITCH_BITS-1:0];
            REG_BASE:  base_address    = value;
            default:   ;
        endcase
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bit_val;
        root    = 0;
        bit_val = 64'd1 << 62;
        while (bit_val > n)
            bit_val = bit_val >> 2;
        while (bit_val != 0)
        begin
            if (n >= root + bit_val)
            begin
                n    = n - (root + bit_val);
                root = (root >> 1) + bit_val;
            end
            else
                root = root >> 1;
            bit_val = bit_val >> 2;
        end
        return root;
    endfunction

    // Signed difference scaled by 2^FRAC_BITS, divided with truncation to zero.
    static function longint scaled_quotient(longint diff, longint count);
        longint unsigned mag;
        longint unsigned quo;
        mag = (diff < 0) ? -diff : diff;
        quo = (mag << FRAC_BITS) / count;
        return (diff < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    static function longint fix_to_int(longint v);
        if (v >= 0)
            return v >>> FRAC_BITS;
        return -((-v) >>> FRAC_BITS);
    endfunction

    function void note_request(request_t req);
        longint dx;
        longint dy;
        longint dc;
        longint count;
        longint xi;
        longint yi;
        longint ci;
        longint unsigned addr;
        result_t pix;
        if (req.mode == MODE_LOAD)
        begin
            dx    = longint'(req.end_x) - longint'(req.start_x);
            dy    = longint'(req.end_y) - longint'(req.start_y);
            dc    = longint'({1'b0, req.end_color}) - longint'({1'b0, req.start_color});
            count = longint'(int_sqrt(dx * dx + dy * dy));
            pixels_left = count[CNT_BITS-1:0];
            x_pos       = POS_BITS'(longint'(req.start_x) <<< FRAC_BITS);
            y_pos       = POS_BITS'(longint'(req.start_y) <<< FRAC_BITS);
            color_acc   = CACC_BITS'(longint'({1'b0, req.start_color}) <<< FRAC_BITS);
            if (pixels_left == 0)
            begin
                x_inc     = '0;
                y_inc     = '0;
                color_inc = '0;
            end
            else
            begin
                x_inc     = INC_BITS'(scaled_quotient(dx, pixels_left));
                y_inc     = INC_BITS'(scaled_quotient(dy, pixels_left));
                color_inc = CACC_BITS'(scaled_quotient(dc, pixels_left));
            end
            return;
        end
        if (pixels_left == 0)
            return;
        xi   = fix_to_int(longint'($signed(x_pos)));
        yi   = fix_to_int(longint'($signed(y_pos)));
        ci   = fix_to_int(longint'($signed(color_acc)));
        addr = longint'(base_address) + xi * longint'(bytes_per_pixel)
             + yi * longint'(row_pitch);
        pix.pixel_address = addr[ADDR_BITS-1:0];
        pix.pixel_color   = ci[COLOR_BITS-1:0];
        pix.last_pixel    = (pixels_left == 1);
        pending_pixels.push_back(pix);
        x_pos       = x_pos + POS_BITS'($signed(x_inc));
        y_pos       = y_pos + POS_BITS'($signed(y_inc));
        color_acc   = color_acc + color_inc;
        pixels_left = pixels_left - 1'b1;
    endfunction

    function void check_pixel(result_t got);
        result_t want;
        pixels_seen++;
        if (pending_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel: addr %h color %h last %b",
                         got.pixel_address, got.pixel_color, got.last_pixel);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.pixel_address !== want.pixel_address || got.pixel_color !== want.pixel_color
            || got.last_pixel !== want.last_pixel)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("pixel mismatch: expected addr %h color %h last %b, got %h %h %b",
                         want.pixel_address, want.pixel_color, want.last_pixel,
                         got.pixel_address, got.pixel_color, got.last_pixel);
        end
    endfunction
endclass

module dda_line_color_interpolator_top_test
    import dda_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;

    logic                 clk;
    logic                 rst_n;
    logic                 request_valid;
    logic                 request_stall;
    request_t             request;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;
    logic                 write_en;
    logic [1:0]           write_index;
    logic [ADDR_BITS-1:0] write_data;

    pixel_scoreboard      board;
    int                   cycle_count;
    int                   hold_off_cycles;
    bit                   stall_enable;

    dda_line_color_interpolator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .request_valid(request_valid),
        .request_stall(request_stall),
        .request      (request),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .write_en     (write_en),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Results are sampled and checked at the edge, before the edge's updates.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_pixel(result);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver stall pattern; a long hold-off takes priority when requested.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            result_stall    <= 1'b1;
        end
        else if (stall_enable)
            result_stall <= ($urandom_range(0, 3) == 0);
        else
            result_stall <= 1'b0;
    end

    task automatic write_reg(logic [1:0] index, logic [ADDR_BITS-1:0] value);
        write_en    <= 1'b1;
        write_index <= index;
        write_data  <= value;
        @(posedge clk);
        board.write_register(index, value);
        write_en    <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one request and holds it until the block takes it.
    task automatic send_request(request_t req, bit keep_valid);
        request_valid <= 1'b1;
        request       <= req;
        do
            @(posedge clk);
        while (request_stall);
        board.note_request(req);
        if (!keep_valid)
        begin
            request_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic release_valid();
        request_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic idle_gap();
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            request_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic request_t load_request(int sx, int sy, int ex, int ey,
                                              int sc, int ec);
        request_t req;
        req.mode        = MODE_LOAD;
        req.start_x     = sx[COORD_BITS-1:0];
        req.start_y     = sy[COORD_BITS-1:0];
        req.end_x       = ex[COORD_BITS-1:0];
        req.end_y       = ey[COORD_BITS-1:0];
        req.start_color = sc[COLOR_BITS-1:0];
        req.end_color   = ec[COLOR_BITS-1:0];
        return req;
    endfunction

    function automatic request_t step_request();
        request_t     req;
        logic [127:0] noise;
        noise    = {$urandom, $urandom, $urandom, $urandom};
        req      = noise[$bits(request_t)-1:0];
        req.mode = MODE_STEP;
        return req;
    endfunction

    function automatic request_t random_load(bit short_line);
        int sx;
        int sy;
        sx = $urandom_range(0, 4095) - 2048;
        sy = $urandom_range(0, 4095) - 2048;
        if (short_line)
            return load_request(sx, sy, sx + $urandom_range(0, 16) - 8,
                                sy + $urandom_range(0, 16) - 8,
                                $urandom_range(0, 16777215), $urandom_range(0, 16777215));
        return load_request(sx, sy, $urandom_range(0, 4095) - 2048,
                            $urandom_range(0, 4095) - 2048,
                            $urandom_range(0, 16777215), $urandom_range(0, 16777215));
    endfunction

    task automatic drain();
        while (board.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic steps(int n, bit keep_valid);
        repeat (n) send_request(step_request(), keep_valid);
    endtask

    initial
    begin
        int items;
        int n;
        board           = new();
        cycle_count     = 0;
        hold_off_cycles = 0;
        stall_enable    = 1'b0;
        rst_n           = 1'b0;
        request_valid   = 1'b0;
        request         = '0;
        result_stall    = 1'b0;
        write_en        = 1'b0;
        write_index     = REG_BPP;
        write_data      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Steps before any load, a zero-length line, and corner lines.
        steps(2, 1'b0);
        send_request(load_request(5, 5, 5, 5, 100, 200), 1'b0);
        steps(2, 1'b0);
        send_request(load_request(-2048, -2048, 2047, 2047, 0, 24'hFFFFFF), 1'b0);
        steps(6, 1'b1);
        release_valid();
        send_request(load_request(2047, -2048, -2048, 2047, 24'hFFFFFF, 0), 1'b0);
        steps(4, 1'b0);
        send_request(load_request(0, 0, 3, 4, 10, 0), 1'b0);
        steps(6, 1'b1);
        send_request(load_request(0, 0, -1, 0, 24'h123456, 24'hABCDEF), 1'b0);
        steps(2, 1'b0);
        drain();

        write_reg(REG_BPP, 0);
        write_reg(REG_PITCH, 16'hFFFF);
        write_reg(REG_BASE, 32'hFFFF_FFFF);
        send_request(load_request(-3, 7, 9, -5, 0, 24'hFFFFFF), 1'b0);
        steps(3, 1'b0);
        drain();

        // Fill the block while the receiver holds off for a long stretch.
        write_reg(REG_BPP, 4'hF);
        write_reg(REG_PITCH, 0);
        write_reg(REG_BASE, 0);
        send_request(load_request(0, 0, 100, 30, 0, 24'h00FF00), 1'b0);
        hold_off_cycles = 200;
        steps(20, 1'b1);
        request_valid <= 1'b0;
        drain();

        stall_enable = 1'b1;
        items = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_BPP, 1); write_reg(REG_PITCH, 640); end
                1: begin write_reg(REG_BPP, 8); write_reg(REG_PITCH, $urandom); end
                2: write_reg(REG_BASE, $urandom);
                default: begin write_reg(REG_BPP, $urandom_range(0, 15));
                    write_reg(REG_PITCH, 4096); end
            endcase
            while (items < (phase + 1) * 125)
            begin
                stall_enable = ($urandom_range(0, 4) != 0);
                if ($urandom_range(0, 9) == 0)
                begin
                    send_request(step_request(), 1'b0);
                    items++;
                end
                else
                begin
                    send_request(random_load($urandom_range(0, 7) != 0), 1'b0);
                    items++;
                    n = (board.pixels_left > 30) ? 30 : board.pixels_left;
                    n = n + $urandom_range(0, 2);
                    for (int i = 0; i < n; i++)
                    begin
                        send_request(step_request(), 1'b1);
                        items++;
                        if ($urandom_range(0, 5) == 0)
                            idle_gap();
                    end
                    release_valid();
                end
                idle_gap();
            end
            drain();
        end

        if (board.mismatches == 0 && board.pending_pixels.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/dda_pkg.sv
sv/dda_isqrt.sv
sv/dda_div.sv
sv/dda_line_color_interpolator_top.sv
verif/dda_line_color_interpolator_top_test.sv
